>>> design/kpec_pkg.sv
// Shared types and constants for the key press event classifier.
// No dependencies; imported by every module of the block.
package kpec_pkg;

    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 40;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [16:0] AWAKE_EXTRA = 17'd50;
    localparam logic [16:0] SINCE_MAX   = 17'h1FFFF;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_CHANNEL_INDEX  = 3'd0,
        REG_MAX_PRESSES    = 3'd1,
        REG_MULTI_TIMEOUT  = 3'd2,
        REG_LONG_TIMEOUT   = 3'd3,
        REG_SECOND_LONG    = 3'd4,
        REG_DEBOUNCE       = 3'd5,
        REG_REPEAT_DELAY   = 3'd6
    } cfg_idx_t;

    typedef enum logic [3:0] {
        EV_SHORT            = 4'd0,
        EV_MULTI            = 4'd1,
        EV_LONG             = 4'd2,
        EV_REPEAT           = 4'd3,
        EV_LONG_END         = 4'd4,
        EV_DOUBLE_LONG      = 4'd5,
        EV_SINGLE_TIMEOUT   = 4'd6,
        EV_DOUBLE_TIMEOUT   = 4'd7,
        EV_RESET_DOUBLE     = 4'd8,
        EV_KEY_DOWN         = 4'd9
    } ev_code_t;

    typedef struct packed {
        logic [7:0]  channel_index;
        logic [7:0]  max_presses;
        logic [15:0] multi_timeout_ms;
        logic [15:0] long_timeout_ms;
        logic [15:0] second_long_timeout_ms;
        logic [7:0]  debounce_ms;
        logic [15:0] repeat_delay_ms;
    } cfg_t;

    typedef struct packed {
        logic        valid;
        ev_code_t    code;
        logic [7:0]  press_count;
        logic        awake_valid;
        logic [16:0] awake_ms;
    } event_t;

endpackage

>>> design/kpec_cfg.sv
// Configuration register file of the key press event classifier.
// Depends on kpec_pkg for the register indexes and the cfg_t bundle.
module kpec_cfg
    import kpec_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_addr)
                REG_CHANNEL_INDEX: cfg_next.channel_index          = cfg_wdata[7:0];
                REG_MAX_PRESSES:   cfg_next.max_presses            = cfg_wdata[7:0];
                REG_MULTI_TIMEOUT: cfg_next.multi_timeout_ms       = cfg_wdata;
                REG_LONG_TIMEOUT:  cfg_next.long_timeout_ms        = cfg_wdata;
                REG_SECOND_LONG:   cfg_next.second_long_timeout_ms = cfg_wdata;
                REG_DEBOUNCE:      cfg_next.debounce_ms            = cfg_wdata[7:0];
                REG_REPEAT_DELAY:  cfg_next.repeat_delay_ms        = cfg_wdata;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.channel_index          <= 8'd0;
            cfg_reg.max_presses            <= 8'd255;
            cfg_reg.multi_timeout_ms       <= 16'd0;
            cfg_reg.long_timeout_ms        <= 16'd400;
            cfg_reg.second_long_timeout_ms <= 16'd1000;
            cfg_reg.debounce_ms            <= 8'd5;
            cfg_reg.repeat_delay_ms        <= 16'd250;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> design/kpec_core.sv
// Key state registers and the single-pass classifier logic.
// Depends on kpec_pkg; state advances once per accepted transaction.
module kpec_core
    import kpec_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   take,
    input  logic   req_type,
    input  logic   key_level,
    input  cfg_t   cfg,
    output event_t evt
);

    logic        level_now_reg,     level_now_next;
    logic        level_seen_reg,    level_seen_next;
    logic        check_pending_reg, check_pending_next;
    logic [15:0] wait_left_reg,     wait_left_next;
    logic [16:0] since_key_reg,     since_key_next;
    logic [7:0]  count_reg,         count_next;
    logic        long_seen_reg,     long_seen_next;
    logic        repeating_reg,     repeating_next;
    logic        double_done_reg,   double_done_next;
    logic [16:0] last_awake_reg,    last_awake_next;

    always_comb
    begin
        logic        fire;
        logic        has_ev;
        ev_code_t    code;
        logic [16:0] awake;
        logic        aw_ok;

        level_now_next     = level_now_reg;
        level_seen_next    = level_seen_reg;
        check_pending_next = check_pending_reg;
        wait_left_next     = wait_left_reg;
        since_key_next     = since_key_reg;
        count_next         = count_reg;
        long_seen_next     = long_seen_reg;
        repeating_next     = repeating_reg;
        double_done_next   = double_done_reg;
        last_awake_next    = last_awake_reg;
        has_ev             = 1'b0;
        code               = EV_KEY_DOWN;
        awake              = '0;
        aw_ok              = 1'b0;
        fire               = 1'b0;

        if (req_type)
        begin
            level_now_next     = key_level;
            wait_left_next     = {8'd0, cfg.debounce_ms};
            check_pending_next = 1'b1;
        end
        else
        begin
            if (wait_left_reg != 16'd0)
                wait_left_next = wait_left_reg - 16'd1;
            if (since_key_reg != SINCE_MAX)
                since_key_next = since_key_reg + 17'd1;
            fire = check_pending_reg && (wait_left_next == 16'd0);
        end

        if (fire)
        begin
            if (!level_now_reg && level_seen_reg && (count_reg < cfg.max_presses))
                count_next = count_reg + 8'd1;

            if (level_now_reg && level_seen_reg)
            begin
                // released and settled: close out a multi press or the double-long window
                if (count_reg != 8'd0)
                begin
                    has_ev             = 1'b1;
                    code               = (cfg.multi_timeout_ms != 16'd0) ? EV_MULTI
                                                                         : EV_SINGLE_TIMEOUT;
                    check_pending_next = 1'b0;
                    long_seen_next     = 1'b0;
                end
                if (long_seen_next && (since_key_next >= {1'b0, cfg.second_long_timeout_ms}))
                begin
                    has_ev         = 1'b1;
                    code           = EV_DOUBLE_TIMEOUT;
                    long_seen_next = 1'b0;
                end
                if (long_seen_next)
                    wait_left_next = cfg.second_long_timeout_ms;
            end
            else if (!level_now_reg && level_seen_reg)
            begin
                since_key_next     = '0;
                wait_left_next     = cfg.long_timeout_ms;
                level_seen_next    = 1'b0;
                check_pending_next = 1'b1;
                has_ev             = 1'b1;
                code               = EV_KEY_DOWN;
            end
            else if (level_now_reg && !level_seen_reg)
            begin
                if (repeating_reg)
                begin
                    repeating_next = 1'b0;
                    has_ev         = 1'b1;
                    code           = EV_LONG_END;
                end
                else if (long_seen_reg)
                begin
                    if (!double_done_reg)
                    begin
                        has_ev = 1'b1;
                        code   = EV_RESET_DOUBLE;
                    end
                    double_done_next = 1'b0;
                end
                else if ((cfg.multi_timeout_ms == 16'd0) && (count_reg == 8'd1))
                begin
                    has_ev = 1'b1;
                    code   = EV_SHORT;
                end
                if ((count_reg != 8'd0) && (cfg.multi_timeout_ms != 16'd0))
                    wait_left_next = cfg.multi_timeout_ms;
                long_seen_next     = 1'b0;
                check_pending_next = 1'b1;
                level_seen_next    = 1'b1;
                since_key_next     = '0;
            end
            else
            begin
                has_ev = 1'b1;
                if (repeating_reg)
                begin
                    wait_left_next = cfg.repeat_delay_ms;
                    code           = EV_REPEAT;
                end
                else if (long_seen_reg)
                begin
                    repeating_next     = 1'b0;
                    check_pending_next = 1'b0;
                    double_done_next   = 1'b1;
                    code               = EV_DOUBLE_LONG;
                end
                else
                begin
                    long_seen_next = 1'b1;
                    repeating_next = 1'b1;
                    wait_left_next = cfg.repeat_delay_ms;
                    code           = EV_LONG;
                end
            end
        end

        if (has_ev)
        begin
            awake = {1'b0, wait_left_next} + AWAKE_EXTRA;
            aw_ok = (last_awake_reg <= awake);
            if (aw_ok)
                last_awake_next = awake;
            // sequence-ending events clear the counter and the awake floor
            if ((code == EV_MULTI) || (code == EV_LONG_END) || (code == EV_SINGLE_TIMEOUT))
            begin
                count_next      = '0;
                last_awake_next = '0;
            end
        end

        evt.valid       = has_ev;
        evt.code        = code;
        evt.press_count = (has_ev && !level_now_reg && level_seen_reg) ? count_next : count_reg;
        evt.awake_valid = aw_ok;
        evt.awake_ms    = aw_ok ? awake : 17'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_now_reg     <= 1'b1;
            level_seen_reg    <= 1'b1;
            check_pending_reg <= 1'b0;
            wait_left_reg     <= '0;
            since_key_reg     <= '0;
            count_reg         <= '0;
            long_seen_reg     <= 1'b0;
            repeating_reg     <= 1'b0;
            double_done_reg   <= 1'b0;
            last_awake_reg    <= '0;
        end
        else if (take)
        begin
            level_now_reg     <= level_now_next;
            level_seen_reg    <= level_seen_next;
            check_pending_reg <= check_pending_next;
            wait_left_reg     <= wait_left_next;
            since_key_reg     <= since_key_next;
            count_reg         <= count_next;
            long_seen_reg     <= long_seen_next;
            repeating_reg     <= repeating_next;
            double_done_reg   <= double_done_next;
            last_awake_reg    <= last_awake_next;
        end
    end

endmodule

>>> design/key_press_event_classifier.sv
// Key press event classifier for one active-low key. Each input transaction is either a
// 1 ms tick (s_tuser = 0) or a new key level (s_tuser = 1, level in s_tdata[0]). One
// transaction is accepted per clock while s_tready is high and is classified in the same
// cycle against the key state registers; at most one event results, held in the output
// register. s_tready drops only while that register holds an event not yet taken.
module key_press_event_classifier
    import kpec_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // [0] key_level, [7:1] zero
    input  logic [0:0]            s_tuser,   // [0] req_type
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // [7:0] event_channel, [11:8] event_code,
                                             // [19:12] press_count, [20] awake_valid,
                                             // [37:21] awake_ms, [39:38] zero
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    cfg_t   cfg;
    event_t evt;
    logic   take;

    logic                  out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg,  out_data_next;

    kpec_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    kpec_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .req_type  (s_tuser[0]),
        .key_level (s_tdata[0]),
        .cfg       (cfg),
        .evt       (evt)
    );

    assign s_tready = !out_valid_reg || m_tready;
    assign take     = s_tvalid && s_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (take)
        begin
            out_valid_next = evt.valid;
            out_data_next  = {2'b00, evt.awake_ms, evt.awake_valid, evt.press_count,
                              evt.code, cfg.channel_index};
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // an unreported awake time reads as zero
    a_awake_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[20]) |-> (m_tdata[37:21] == 17'd0))
        else $error("awake_ms nonzero without awake_valid");

    // a reported awake time always carries the 50 ms margin
    a_awake_min: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[20]) |-> (m_tdata[37:21] >= AWAKE_EXTRA))
        else $error("awake_ms below margin");

    // a level-change transaction never produces an event
    a_level_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser[0]) |=> !m_tvalid)
        else $error("event after level change");

endmodule

>>> bench/tb_key_press_event_classifier.sv
// Self-checking bench for key_press_event_classifier: drives ticks and key level changes,
// predicts each event from a behavioral model of the classifier and checks the output stream.
// Depends on kpec_pkg and the key_press_event_classifier RTL.
module tb_key_press_event_classifier;
    import kpec_pkg::*;

    localparam bit REQ_TICK     = 1'b0;
    localparam bit REQ_LEVEL    = 1'b1;
    localparam bit LVL_PRESSED  = 1'b0;
    localparam bit LVL_RELEASED = 1'b1;
    localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 3'd7;
    localparam int SETTLE_CYCLES = 4;
    localparam int MAX_REPORTS   = 10;

    // same order as m_tdata[37:0], lowest field last
    typedef struct packed {
        logic [16:0] awake_ms;
        logic        awake_valid;
        logic [7:0]  presses;
        ev_code_t    code;
        logic [7:0]  channel;
    } key_event_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic [0:0]            s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int items_sent     = 0;
    int mismatch_count = 0;

    key_event_t pending_events[$];

    // shadow of the registers and key state
    cfg_t        key_cfg;
    bit          lvl_cur;
    bit          lvl_acted;
    bit          check_armed;
    bit          long_held;
    bit          repeat_on;
    bit          dbl_done;
    logic [15:0] wait_ms;
    logic [16:0] since_press_ms;
    logic [7:0]  presses;
    logic [16:0] awake_last;

    key_press_event_classifier dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic void predict_key_event(input bit req, input bit lvl);
        bit          fired;
        ev_code_t    code;
        logic [16:0] awake;
        key_event_t  ev;
        fired = 1'b0;
        code  = EV_KEY_DOWN;
        if (req == REQ_LEVEL)
        begin
            lvl_cur     = lvl;
            wait_ms     = {8'd0, key_cfg.debounce_ms};
            check_armed = 1'b1;
            return;
        end
        if (wait_ms != 16'd0)
            wait_ms--;
        if (since_press_ms < SINCE_MAX)
            since_press_ms++;
        if (!check_armed || wait_ms != 16'd0)
            return;

        if (lvl_cur == LVL_PRESSED && lvl_acted == LVL_RELEASED
            && presses < key_cfg.max_presses)
            presses++;

        if (lvl_cur == LVL_RELEASED && lvl_acted == LVL_RELEASED)
        begin
            if (presses != 8'd0)
            begin
                fired       = 1'b1;
                code        = (key_cfg.multi_timeout_ms != 16'd0) ? EV_MULTI
                                                                   : EV_SINGLE_TIMEOUT;
                check_armed = 1'b0;
                long_held   = 1'b0;
            end
            if (long_held && since_press_ms >= {1'b0, key_cfg.second_long_timeout_ms})
            begin
                fired     = 1'b1;
                code      = EV_DOUBLE_TIMEOUT;
                long_held = 1'b0;
            end
            if (long_held)
                wait_ms = key_cfg.second_long_timeout_ms;
        end
        else if (lvl_cur == LVL_PRESSED && lvl_acted == LVL_RELEASED)
        begin
            since_press_ms = '0;
            wait_ms        = key_cfg.long_timeout_ms;
            lvl_acted      = LVL_PRESSED;
            check_armed    = 1'b1;
            fired          = 1'b1;
            code           = EV_KEY_DOWN;
        end
        else if (lvl_cur == LVL_RELEASED && lvl_acted == LVL_PRESSED)
        begin
            if (repeat_on)
            begin
                repeat_on = 1'b0;
                fired     = 1'b1;
                code      = EV_LONG_END;
            end
            else if (long_held)
            begin
                if (!dbl_done)
                begin
                    fired = 1'b1;
                    code  = EV_RESET_DOUBLE;
                end
                dbl_done = 1'b0;
            end
            else if (key_cfg.multi_timeout_ms == 16'd0 && presses == 8'd1)
            begin
                fired = 1'b1;
                code  = EV_SHORT;
            end
            if (presses != 8'd0 && key_cfg.multi_timeout_ms != 16'd0)
                wait_ms = key_cfg.multi_timeout_ms;
            long_held      = 1'b0;
            check_armed    = 1'b1;
            lvl_acted      = LVL_RELEASED;
            since_press_ms = '0;
        end
        else
        begin
            fired = 1'b1;
            if (repeat_on)
            begin
                wait_ms = key_cfg.repeat_delay_ms;
                code    = EV_REPEAT;
            end
            else if (long_held)
            begin
                repeat_on   = 1'b0;
                check_armed = 1'b0;
                dbl_done    = 1'b1;
                code        = EV_DOUBLE_LONG;
            end
            else
            begin
                long_held = 1'b1;
                repeat_on = 1'b1;
                wait_ms   = key_cfg.repeat_delay_ms;
                code      = EV_LONG;
            end
        end

        if (!fired)
            return;
        awake          = {1'b0, wait_ms} + AWAKE_EXTRA;
        ev.channel     = key_cfg.channel_index;
        ev.code        = code;
        ev.presses     = presses;
        ev.awake_valid = (awake_last <= awake);
        ev.awake_ms    = ev.awake_valid ? awake : 17'd0;
        if (ev.awake_valid)
            awake_last = awake;
        // these events close the sequence
        if (code == EV_MULTI || code == EV_LONG_END || code == EV_SINGLE_TIMEOUT)
        begin
            presses    = 8'd0;
            awake_last = '0;
        end
        pending_events.push_back(ev);
    endfunction

    // output side: random backpressure and event check
    always @(posedge clk)
    begin : check_events
        key_event_t got;
        key_event_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = key_event_t'(m_tdata[37:0]);
            if (pending_events.size() == 0)
            begin
                if (mismatch_count < MAX_REPORTS)
                    $display("%0t: unexpected event ch=%0d code=%0d cnt=%0d av=%0b ms=%0d",
                             $realtime, got.channel, got.code, got.presses,
                             got.awake_valid, got.awake_ms);
                mismatch_count++;
            end
            else
            begin
                want = pending_events.pop_front();
                if (got !== want || m_tdata[OUT_DATA_W-1:38] !== '0)
                begin
                    if (mismatch_count < MAX_REPORTS)
                    begin
                        $display("%0t: mismatch: want ch=%0d code=%0d cnt=%0d av=%0b ms=%0d",
                                 $realtime, want.channel, want.code, want.presses,
                                 want.awake_valid, want.awake_ms);
                        $display("%0t:   got ch=%0d code=%0d cnt=%0d av=%0b ms=%0d pad=%0h",
                                 $realtime, got.channel, got.code, got.presses,
                                 got.awake_valid, got.awake_ms, m_tdata[OUT_DATA_W-1:38]);
                    end
                    mismatch_count++;
                end
            end
        end
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // one input transaction; s_tvalid stays high on return
    task automatic send_item(input bit req, input bit lvl);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {{(IN_DATA_W-1){1'b0}}, lvl};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_key_event(req, lvl);
        items_sent++;
    endtask

    task automatic ticks(input int n);
        repeat (n)
            send_item(REQ_TICK, 1'($urandom_range(0, 1)));
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic set_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [15:0] value);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= value;
        @(posedge clk);
        case (addr)
            REG_CHANNEL_INDEX: key_cfg.channel_index          = value[7:0];
            REG_MAX_PRESSES:   key_cfg.max_presses            = value[7:0];
            REG_MULTI_TIMEOUT: key_cfg.multi_timeout_ms       = value;
            REG_LONG_TIMEOUT:  key_cfg.long_timeout_ms        = value;
            REG_SECOND_LONG:   key_cfg.second_long_timeout_ms = value;
            REG_DEBOUNCE:      key_cfg.debounce_ms            = value[7:0];
            REG_REPEAT_DELAY:  key_cfg.repeat_delay_ms        = value;
            default: ;
        endcase
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // reset register values: key down, short, single timeout, idle re-arm
    task automatic test_default_config();
        send_item(REQ_LEVEL, LVL_PRESSED);
        ticks(5);
        send_item(REQ_LEVEL, LVL_RELEASED);
        ticks(6);
        send_item(REQ_LEVEL, LVL_RELEASED);
        ticks(2);
    endtask

    task automatic test_long_and_repeat();
        settle();
        set_reg(REG_CHANNEL_INDEX, 16'd255);
        set_reg(REG_MULTI_TIMEOUT, 16'd0);
        set_reg(REG_LONG_TIMEOUT, 16'd2);
        set_reg(REG_SECOND_LONG, 16'd3);
        set_reg(REG_DEBOUNCE, 16'd0);
        set_reg(REG_REPEAT_DELAY, 16'd1);
        send_item(REQ_LEVEL, LVL_PRESSED);
        ticks(5);
        send_item(REQ_LEVEL, LVL_RELEASED);
        ticks(2);
    endtask

    // three presses inside the multi window, count capped at two
    task automatic test_multi_press_limit();
        settle();
        set_reg(REG_CHANNEL_INDEX, 16'h005A);
        set_reg(REG_MAX_PRESSES, 16'd2);
        set_reg(REG_MULTI_TIMEOUT, 16'd3);
        repeat (3)
        begin
            send_item(REQ_LEVEL, LVL_PRESSED);
            ticks(1);
            send_item(REQ_LEVEL, LVL_RELEASED);
            ticks(1);
        end
        ticks(3);
    endtask

    task automatic test_register_extremes();
        settle();
        set_reg(REG_MAX_PRESSES, 16'd0);
        set_reg(REG_MULTI_TIMEOUT, 16'd0);
        set_reg(REG_LONG_TIMEOUT, 16'hFFFF);
        send_item(REQ_LEVEL, LVL_PRESSED);
        ticks(1);
        send_item(REQ_LEVEL, LVL_RELEASED);
        ticks(2);
        settle();
        set_reg(REG_UNUSED, 16'hFFFF);
        set_reg(REG_DEBOUNCE, 16'd255);
        send_item(REQ_LEVEL, LVL_PRESSED);
        ticks(3);
    endtask

    // held with every timer at full scale but debounce, whose written low byte is zero
    task automatic test_saturating_hold();
        settle();
        set_reg(REG_CHANNEL_INDEX, 16'hFFFF);
        set_reg(REG_MAX_PRESSES, 16'd255);
        set_reg(REG_MULTI_TIMEOUT, 16'hFFFF);
        set_reg(REG_LONG_TIMEOUT, 16'hFFFF);
        set_reg(REG_SECOND_LONG, 16'hFFFF);
        set_reg(REG_DEBOUNCE, 16'hFF00);
        set_reg(REG_REPEAT_DELAY, 16'hFFFF);
        send_item(REQ_LEVEL, LVL_PRESSED);
        ticks(12);
        send_item(REQ_LEVEL, LVL_RELEASED);
        ticks(1);
    endtask

    task automatic test_random_phases();
        int idle_sched[4]  = '{0, 67, 0, 11};
        int stall_sched[4] = '{0, 0, 67, 11};
        int target;
        int hold;
        bit held_off;
        held_off = 1'b0;
        for (int ph = 0; ph < 4; ph++)
        begin
            settle();
            send_idle_pct  = idle_sched[ph];
            recv_stall_pct = stall_sched[ph];
            set_reg(REG_CHANNEL_INDEX, 16'($urandom_range(0, 255)));
            set_reg(REG_MAX_PRESSES,
                    ($urandom_range(0, 3) == 0) ? 16'd255 : 16'($urandom_range(0, 4)));
            set_reg(REG_MULTI_TIMEOUT,
                    ($urandom_range(0, 1) == 0) ? 16'd0 : 16'($urandom_range(2, 8)));
            set_reg(REG_LONG_TIMEOUT, 16'($urandom_range(0, 12)));
            set_reg(REG_SECOND_LONG, 16'($urandom_range(0, 15)));
            set_reg(REG_DEBOUNCE, 16'($urandom_range(0, 3)));
            set_reg(REG_REPEAT_DELAY, 16'($urandom_range(1, 5)));
            target = items_sent + 100;
            while (items_sent < target)
            begin
                if (!held_off && ph == 1 && items_sent >= target - 50)
                begin
                    settle();
                    held_off = 1'b1;
                end
                if ($urandom_range(0, 9) == 0)
                    send_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                else
                begin
                    // contact bounce ahead of the real press
                    repeat ($urandom_range(0, 2))
                        send_item(REQ_LEVEL, 1'($urandom_range(0, 1)));
                    send_item(REQ_LEVEL, LVL_PRESSED);
                    if ($urandom_range(0, 3) == 0)
                        hold = $urandom_range(0, 3);
                    else
                        hold = $urandom_range(0, key_cfg.long_timeout_ms
                                                 + 4 * key_cfg.repeat_delay_ms + 4);
                    ticks(hold);
                    if ($urandom_range(0, 3) == 0)
                        send_item(REQ_LEVEL, 1'($urandom_range(0, 1)));
                    send_item(REQ_LEVEL, LVL_RELEASED);
                    ticks($urandom_range(0, key_cfg.multi_timeout_ms
                                            + key_cfg.debounce_ms + 4));
                end
            end
        end
    endtask

    initial
    begin
        key_cfg = '{channel_index: 8'd0, max_presses: 8'd255, multi_timeout_ms: 16'd0,
                    long_timeout_ms: 16'd400, second_long_timeout_ms: 16'd1000,
                    debounce_ms: 8'd5, repeat_delay_ms: 16'd250};
        lvl_cur        = LVL_RELEASED;
        lvl_acted      = LVL_RELEASED;
        check_armed    = 1'b0;
        long_held      = 1'b0;
        repeat_on      = 1'b0;
        dbl_done       = 1'b0;
        wait_ms        = '0;
        since_press_ms = '0;
        presses        = '0;
        awake_last     = '0;
        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_config();
        test_long_and_repeat();
        test_multi_press_limit();
        test_register_extremes();
        test_saturating_hold();
        test_random_phases();

        settle();
        if (mismatch_count == 0)
            $display("tb_key_press_event_classifier: clean");
        else
            $display("tb_key_press_event_classifier: errors");
        $finish;
    end

    initial
    begin
        #40_000_000;
        $display("tb_key_press_event_classifier: errors");
        $finish;
    end

endmodule
